/* rtl/kmp_pkg.sv */
// kmp_pkg: shared opcodes, widths, defaults and the result struct of the kmp stream matcher
// no dependencies; imported by kmp_seq, kmp_out and kmp_stream_matcher
package kmp_pkg;

	// fixed field widths of the stream words
	localparam int OPCODE_W = 2;
	localparam int SYMBOL_W = 8;
	localparam int POS_W    = 32;

	// parameter defaults
	localparam int MAX_PATTERN_DEF = 64;
	localparam int SYMBOL_BITS_DEF = 8;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TEXT   = 2'd2;

	// one finished text result, handed from the sequencer to the output register
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] start;
	} result_t;

endpackage

/* rtl/kmp_ram.sv */
// kmp_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies; holds the pattern symbols and the failure table
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/kmp_seq.sv */
// kmp_seq: sequencer that walks failure links through the two rams for appends and text words
// depends on kmp_pkg; drives the ram ports of kmp_ram and feeds results to kmp_out
module kmp_seq #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
	parameter int SYMBOL_BITS = kmp_pkg::SYMBOL_BITS_DEF,
	localparam int CNT_W = $clog2(MAX_PATTERN + 1),
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kmp_pkg::OPCODE_W-1:0]  opcode,
	input  logic [kmp_pkg::SYMBOL_W-1:0]  symbol,
	input  logic                          end_of_text,
	// pattern ram
	output logic                          pat_we,
	output logic [AW-1:0]                 pat_waddr,
	output logic [SYMBOL_BITS-1:0]        pat_wdata,
	output logic [AW-1:0]                 pat_raddr,
	input  logic [SYMBOL_BITS-1:0]        pat_rdata,
	// failure ram
	output logic                          fail_we,
	output logic [AW-1:0]                 fail_waddr,
	output logic [CNT_W-1:0]              fail_wdata,
	output logic [AW-1:0]                 fail_raddr,
	input  logic [CNT_W-1:0]              fail_rdata,
	// result path
	input  logic                          res_free,
	output logic                          res_valid,
	output kmp_pkg::result_t              res
);
	import kmp_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                   state_q;
	logic                   is_text_q;
	logic                   last_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       build_q;
	logic [CNT_W-1:0]       match_q;
	logic [POS_W-1:0]       pos_q;

	logic                   accept;
	logic [SYMBOL_BITS-1:0] sym_in;
	logic [CNT_W-1:0]       k_start;
	logic                   hit;
	logic                   step;
	logic                   finish;
	logic [CNT_W-1:0]       nk;
	logic [CNT_W-1:0]       k_fin;
	logic [CNT_W-1:0]       rd_k;
	logic [CNT_W-1:0]       rd_km1;
	logic                   full;
	logic                   found;
	logic                   first_append;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign sym_in   = SYMBOL_BITS'(symbol);
	assign full     = (count_q == CNT_W'(MAX_PATTERN));
	assign first_append = accept && (opcode == OP_APPEND) && (count_q == '0);

	always_comb begin
		k_start = (opcode == OP_TEXT) ? match_q : build_q;
		hit     = (pat_rdata == sym_q);
		// failure links always point strictly back
		nk      = (fail_rdata < k_q) ? fail_rdata : '0;
		step    = (k_q != '0) && !hit;
		k_fin   = k_q + CNT_W'(hit);
		finish  = (state_q == ST_WALK) && !step && (!is_text_q || res_free);
		found   = (count_q != '0) && (k_fin >= count_q);
		if (state_q == ST_IDLE) begin
			rd_k = k_start;
		end else if (step) begin
			rd_k = nk;
		end else begin
			rd_k = k_q;
		end
		rd_km1 = rd_k - CNT_W'(1);
	end

	assign pat_raddr  = rd_k[AW-1:0];
	assign fail_raddr = rd_km1[AW-1:0];

	// writes land at the current end of the pattern
	assign pat_we     = first_append || (finish && !is_text_q);
	assign fail_we    = pat_we;
	assign pat_waddr  = count_q[AW-1:0];
	assign fail_waddr = count_q[AW-1:0];
	assign pat_wdata  = (state_q == ST_IDLE) ? sym_in : sym_q;
	assign fail_wdata = (state_q == ST_IDLE) ? '0 : k_fin;

	assign res_valid  = finish && is_text_q;
	assign res.found  = found;
	assign res.start  = found ? (pos_q - (POS_W'(count_q) - POS_W'(1))) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			is_text_q <= 1'b0;
			last_q    <= 1'b0;
			k_q       <= '0;
			count_q   <= '0;
			build_q   <= '0;
			match_q   <= '0;
			pos_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sym_q     <= sym_in;
						last_q    <= end_of_text;
						is_text_q <= (opcode == OP_TEXT);
						k_q       <= k_start;
						unique case (opcode)
							OP_CLEAR: begin
								count_q <= '0;
								build_q <= '0;
								match_q <= '0;
								pos_q   <= '0;
							end
							OP_APPEND: begin
								if (!full && count_q == '0) begin
									build_q <= '0;
									count_q <= CNT_W'(1);
								end else if (!full) begin
									state_q <= ST_WALK;
								end
							end
							OP_TEXT: begin
								state_q <= ST_WALK;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (step) begin
						k_q <= nk;
					end else if (finish) begin
						state_q <= ST_IDLE;
						if (is_text_q) begin
							if (last_q) begin
								match_q <= '0;
								pos_q   <= '0;
							end else begin
								pos_q <= pos_q + POS_W'(1);
								if (found) begin
									match_q <= build_q;
								end else if (count_q != '0) begin
									match_q <= k_fin;
								end
							end
						end else begin
							build_q <= k_fin;
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a failure-link step always shortens the matched prefix
	a_walk_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && step) |=> (k_q < $past(k_q)))
		else $error("failure walk did not shrink the prefix");

	// match progress stays a proper prefix of the pattern
	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) ? (match_q == '0) : (match_q < count_q))
		else $error("match prefix out of range");

	// border of the pattern is proper
	a_build_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (build_q < count_q))
		else $error("build prefix out of range");

endmodule

/* rtl/kmp_out.sv */
// kmp_out: output holding register that decouples the result word from the sequencer
// depends on kmp_pkg; fed by kmp_seq
module kmp_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       res_valid,
	input  kmp_pkg::result_t           res,
	output logic                       res_free,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       match_found,
	output logic [kmp_pkg::POS_W-1:0]  match_start
);
	import kmp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign res_free    = !valid_q || !out_stall;
	assign out_valid   = valid_q;
	assign match_found = data_q.found;
	assign match_start = data_q.start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q <= res;
		end
	end

	// a held word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |-> !res_valid)
		else $error("result written over a stalled word");

endmodule

/* rtl/kmp_stream_matcher.sv */
// kmp_stream_matcher: top level of the streaming knuth-morris-pratt matcher
// depends on kmp_pkg, kmp_ram, kmp_seq and kmp_out
//
// a pattern of up to MAX_PATTERN symbols is built with append words (opcode 1) and dropped
// with a clear word (opcode 0), which also restarts matching and the text position.
// text words (opcode 2) each give one result word: match_found, and match_start as the
// position (from 0, wrapping at 2^32) where a match ending at this symbol began; overlapping
// matches are reported. end_of_text restarts matching after its symbol. opcode 3 is dropped.
// the pattern symbols and the failure table sit in two synchronous rams with registered
// read data. a clear, a first append or an ignored word is done in the idle state; an append
// or a text word then walks failure links, each costing one ram read round trip, and no new
// word is taken until it is done; over a text stream this averages at most one link per symbol.
// a finished result waits in an output register, so the next word is taken while
// it is stalled; a text word only completes once that register can take its result.
// the rams need no clearing after reset.
module kmp_stream_matcher #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
	parameter int SYMBOL_BITS = kmp_pkg::SYMBOL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kmp_pkg::OPCODE_W-1:0]  opcode,
	input  logic [kmp_pkg::SYMBOL_W-1:0]  symbol,
	input  logic                          end_of_text,
	// result words
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          match_found,
	output logic [kmp_pkg::POS_W-1:0]     match_start
);
	import kmp_pkg::*;

	// prefix lengths run 0..MAX_PATTERN, ram addresses 0..MAX_PATTERN-1
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int AW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic                   pat_we;
	logic [AW-1:0]          pat_waddr;
	logic [SYMBOL_BITS-1:0] pat_wdata;
	logic [AW-1:0]          pat_raddr;
	logic [SYMBOL_BITS-1:0] pat_rdata;
	logic                   fail_we;
	logic [AW-1:0]          fail_waddr;
	logic [CNT_W-1:0]       fail_wdata;
	logic [AW-1:0]          fail_raddr;
	logic [CNT_W-1:0]       fail_rdata;
	logic                   res_free;
	logic                   res_valid;
	result_t                res;

	// pattern symbols
	kmp_ram #(
		.WIDTH (SYMBOL_BITS),
		.DEPTH (MAX_PATTERN)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	// failure table: entry i is the longest proper border of pattern[0..i]
	kmp_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_PATTERN)
	) u_fail_ram (
		.clk   (clk),
		.we    (fail_we),
		.waddr (fail_waddr),
		.wdata (fail_wdata),
		.raddr (fail_raddr),
		.rdata (fail_rdata)
	);

	// sequencer: owns count, borders, match progress and text position
	kmp_seq #(
		.MAX_PATTERN (MAX_PATTERN),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.symbol      (symbol),
		.end_of_text (end_of_text),
		.pat_we      (pat_we),
		.pat_waddr   (pat_waddr),
		.pat_wdata   (pat_wdata),
		.pat_raddr   (pat_raddr),
		.pat_rdata   (pat_rdata),
		.fail_we     (fail_we),
		.fail_waddr  (fail_waddr),
		.fail_wdata  (fail_wdata),
		.fail_raddr  (fail_raddr),
		.fail_rdata  (fail_rdata),
		.res_free    (res_free),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result word register
	kmp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.res_free    (res_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_found (match_found),
		.match_start (match_start)
	);

endmodule
